// ----- design/m4tu_pkg.sv -----
`default_nettype none

package m4tu_pkg;

    // Fixed-point format: two's complement with FRAC_BITS fractional bits.
    localparam int FRAC_BITS = 16;
    localparam int WORD_W    = 32;
    localparam int MAT_DIM   = 4;
    localparam int MAT_SIZE  = MAT_DIM * MAT_DIM;
    localparam int IDX_W     = $clog2(MAT_SIZE);
    localparam int PROD_W    = 2 * WORD_W;
    localparam int SUM_W     = PROD_W + 2;

    localparam logic signed [WORD_W-1:0] FIX_ONE = WORD_W'(1) <<< FRAC_BITS;

    // Operation codes; codes 5 to 7 are unused and return an all-zero item.
    typedef enum logic [2:0] {
        OP_WR_WORK   = 3'd0,
        OP_WR_OPER   = 3'd1,
        OP_APPEND    = 3'd2,
        OP_TRANSPOSE = 3'd3,
        OP_TRANSFORM = 3'd4
    } op_t;

    typedef struct packed {
        logic        [2:0]        opcode;
        logic        [IDX_W-1:0]  entry_index;
        logic signed [WORD_W-1:0] entry_value;
        logic signed [WORD_W-1:0] in_x;
        logic signed [WORD_W-1:0] in_y;
        logic signed [WORD_W-1:0] in_z;
        logic signed [WORD_W-1:0] in_w;
    } in_item_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] out_x;
        logic signed [WORD_W-1:0] out_y;
        logic signed [WORD_W-1:0] out_z;
        logic signed [WORD_W-1:0] out_w;
        logic                     saturated;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             load;     // capture the accepted item
        logic             issue;    // start one dot product
        logic [IDX_W-1:0] idx;      // result entry of that dot product
        logic             use_vec;  // right operand is the vector, not the operand matrix
        logic             finish;   // apply the operation and load the output register
        logic [2:0]       op;       // opcode of the item in flight
    } dp_cmd_t;

endpackage

`default_nettype wire

// ----- design/matrix4_transform_unit.sv -----
`default_nettype none

// Channel   Signals                          Direction  Carries
// -------   -------------------------------  ---------  ------------------------------
// in        in_valid, in_ready, in_item      into unit  one opcode with entry or vector
// out       out_valid, out_ready, out_item   from unit  one result item per input item
//
// Sequence: a write, a transpose or an unused opcode goes from acceptance straight to finish;
// a transform issues four dot products on the four shared 32x32 multipliers, then drains,
// finishes and returns to idle; an append does the same with sixteen dot products. Finish
// waits while a stalled result still holds the output register.
// Reset (rst_n, asynchronous) sets both matrices to the identity and empties the unit.
// A stalled result waits in the output register; one more item is accepted and then waits.

module matrix4_transform_unit
    import m4tu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire in_item_t  in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output out_item_t      out_item
);

    // Commands from the sequencer to the arithmetic and matrix storage.
    dp_cmd_t cmd;

    // The controller walks each item through accept, multiply and drain (append and
    // transform only) and finish, and owns the output valid flag; the datapath holds
    // both matrices, the multipliers, the result buffer and the output payload register.
    m4tu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .opcode    (in_item.opcode),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    m4tu_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_item  (in_item),
        .cmd      (cmd),
        .out_item (out_item)
    );

endmodule

`default_nettype wire

// ----- design/m4tu_dp.sv -----
`default_nettype none

module m4tu_dp
    import m4tu_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire in_item_t  in_item,
    input  wire dp_cmd_t   cmd,
    output out_item_t      out_item
);

    logic        [IDX_W-1:0]  idx_reg;
    logic signed [WORD_W-1:0] val_reg;
    logic signed [WORD_W-1:0] vec_reg  [MAT_DIM];
    logic signed [WORD_W-1:0] work_reg [MAT_SIZE];
    logic signed [WORD_W-1:0] oper_reg [MAT_SIZE];
    logic signed [WORD_W-1:0] res_reg  [MAT_SIZE];
    logic signed [PROD_W-1:0] prod_reg [MAT_DIM];
    logic                     prod_vld_reg;
    logic        [IDX_W-1:0]  prod_idx_reg;
    logic                     sat_reg;
    out_item_t                out_reg;

    logic signed [WORD_W-1:0] a_op [MAT_DIM];
    logic signed [WORD_W-1:0] b_op [MAT_DIM];
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  shifted;
    logic                     clip_hi;
    logic                     clip_lo;
    logic signed [WORD_W-1:0] clipped;

    function automatic logic signed [WORD_W-1:0] identity_entry(input logic [IDX_W-1:0] i);
        return (i[3:2] == i[1:0]) ? FIX_ONE : '0;
    endfunction

    // Entry (basis c, component r) sits at index {c, r}. Result entry {c, r}
    // takes row r of the working matrix and column c of the operand matrix.
    always_comb
    begin
        for (int k = 0; k < MAT_DIM; k++)
        begin
            a_op[k] = work_reg[{2'(k), cmd.idx[1:0]}];
            b_op[k] = cmd.use_vec ? vec_reg[k] : oper_reg[{cmd.idx[3:2], 2'(k)}];
        end
    end

    // Exact sum of the four products, floor shift, then clip to the word.
    always_comb
    begin
        sum = '0;
        for (int k = 0; k < MAT_DIM; k++)
        begin
            sum = sum + SUM_W'(prod_reg[k]);
        end
        shifted = sum >>> FRAC_BITS;
        clip_hi = !shifted[SUM_W-1] && (|shifted[SUM_W-2:WORD_W-1]);
        clip_lo = shifted[SUM_W-1] && !(&shifted[SUM_W-2:WORD_W-1]);
        if (clip_hi)
        begin
            clipped = {1'b0, {(WORD_W-1){1'b1}}};
        end
        else if (clip_lo)
        begin
            clipped = {1'b1, {(WORD_W-1){1'b0}}};
        end
        else
        begin
            clipped = shifted[WORD_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg    <= in_item.entry_index;
            val_reg    <= in_item.entry_value;
            vec_reg[0] <= in_item.in_x;
            vec_reg[1] <= in_item.in_y;
            vec_reg[2] <= in_item.in_z;
            vec_reg[3] <= in_item.in_w;
        end
        if (cmd.issue)
        begin
            for (int k = 0; k < MAT_DIM; k++)
            begin
                prod_reg[k] <= PROD_W'(a_op[k]) * PROD_W'(b_op[k]);
            end
            prod_idx_reg <= cmd.idx;
        end
        if (prod_vld_reg)
        begin
            res_reg[prod_idx_reg] <= clipped;
        end
        if (cmd.finish)
        begin
            if (cmd.op == OP_TRANSFORM)
            begin
                out_reg.out_x <= res_reg[0];
                out_reg.out_y <= res_reg[1];
                out_reg.out_z <= res_reg[2];
                out_reg.out_w <= res_reg[3];
            end
            else
            begin
                out_reg.out_x <= '0;
                out_reg.out_y <= '0;
                out_reg.out_z <= '0;
                out_reg.out_w <= '0;
            end
            out_reg.saturated <= sat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
            sat_reg      <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= cmd.issue;
            if (cmd.load)
            begin
                sat_reg <= 1'b0;
            end
            else if (prod_vld_reg && (clip_hi || clip_lo))
            begin
                sat_reg <= 1'b1;
            end
        end
    end

    // Matrix state: both matrices come out of reset as the identity.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAT_SIZE; i++)
            begin
                work_reg[i] <= identity_entry(IDX_W'(i));
                oper_reg[i] <= identity_entry(IDX_W'(i));
            end
        end
        else if (cmd.finish)
        begin
            unique case (cmd.op)
                OP_WR_WORK:
                begin
                    work_reg[idx_reg] <= val_reg;
                end
                OP_WR_OPER:
                begin
                    oper_reg[idx_reg] <= val_reg;
                end
                OP_APPEND:
                begin
                    for (int i = 0; i < MAT_SIZE; i++)
                    begin
                        work_reg[i] <= res_reg[i];
                    end
                end
                OP_TRANSPOSE:
                begin
                    for (int r = 0; r < MAT_DIM; r++)
                    begin
                        for (int c = 0; c < MAT_DIM; c++)
                        begin
                            work_reg[{2'(c), 2'(r)}] <= work_reg[{2'(r), 2'(c)}];
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign out_item = out_reg;

`ifndef SYNTHESIS
    // The last dot product must be written back before the item completes.
    a_no_finish_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        prod_vld_reg |-> !cmd.finish)
        else $error("item finished while a dot product was still in flight");

    a_no_load_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !prod_vld_reg && !cmd.issue)
        else $error("new item loaded while the multipliers were busy");

    a_vec_rows_only: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && cmd.use_vec) |-> (cmd.idx[3:2] == 2'b00))
        else $error("vector transform issued beyond the first four results");
`endif

endmodule

`default_nettype wire

// ----- design/m4tu_ctrl.sv -----
`default_nettype none

module m4tu_ctrl
    import m4tu_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    input  wire logic [2:0] opcode,
    output logic            in_ready,
    output logic            out_valid,
    input  wire logic       out_ready,
    output dp_cmd_t         cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_MUL   = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] cnt_next;
    logic [2:0]       op_reg;
    logic [2:0]       op_next;
    logic             out_valid_reg;
    logic             out_valid_next;

    logic             slot_free;
    logic             finish;
    logic [IDX_W-1:0] last_idx;

    assign slot_free = !out_valid_reg || out_ready;
    assign last_idx  = (op_reg == OP_APPEND) ? IDX_W'(MAT_SIZE - 1) : IDX_W'(MAT_DIM - 1);
    assign in_ready  = (state_reg == ST_IDLE);
    assign finish    = (state_reg == ST_DONE) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        op_next    = op_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next  = opcode;
                    cnt_next = '0;
                    if ((opcode == OP_APPEND) || (opcode == OP_TRANSFORM))
                    begin
                        state_next = ST_MUL;
                    end
                    else
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_MUL:
            begin
                if (cnt_reg == last_idx)
                begin
                    cnt_next   = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (finish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            op_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd.load    = in_valid && in_ready;
        cmd.issue   = (state_reg == ST_MUL);
        cmd.idx     = cnt_reg;
        cmd.use_vec = (op_reg == OP_TRANSFORM);
        cmd.finish  = finish;
        cmd.op      = op_reg;
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_cnt_idle_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_MUL) |-> (cnt_reg == '0))
        else $error("sequence counter not cleared outside the multiply phase");

    a_transform_four: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && op_reg == OP_TRANSFORM) |->
            $past(cnt_reg) == IDX_W'(MAT_DIM - 1))
        else $error("transform did not issue exactly four dot products");

    a_append_sixteen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DRAIN && op_reg == OP_APPEND) |->
            $past(cnt_reg) == IDX_W'(MAT_SIZE - 1))
        else $error("append did not issue all sixteen dot products");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the completion state");
`endif

endmodule

`default_nettype wire
